// File: src/zmrd_pkg.sv
package zmrd_pkg;

  localparam logic [7:0] B_ZDLE = 8'h18;
  localparam logic [7:0] B_ZPAD = 8'h2A;
  localparam logic [7:0] B_XON  = 8'h11;
  localparam logic [7:0] B_XOFF = 8'h13;
  localparam logic [31:0] CRC32_RESIDUE = 32'hdebb20e3;

  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_IDLE   = 2'd3;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_HEADER = 2'd1;
  localparam logic [1:0] MODE_DATA   = 2'd2;
  localparam logic [1:0] MODE_FINISH = 2'd3;

  localparam logic [1:0] FMT_HEX   = 2'd0;
  localparam logic [1:0] FMT_BIN16 = 2'd1;
  localparam logic [1:0] FMT_BIN32 = 2'd2;

  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_IDLE     = 4'd1;
  localparam logic [3:0] EV_PADS     = 4'd2;
  localparam logic [3:0] EV_HDR_GOOD = 4'd3;
  localparam logic [3:0] EV_HDR_BAD  = 4'd4;
  localparam logic [3:0] EV_DATA     = 4'd5;
  localparam logic [3:0] EV_SUB_END  = 4'd6;
  localparam logic [3:0] EV_FINISH   = 4'd7;
  localparam logic [3:0] EV_CANCEL   = 4'd8;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] v;
    v = {crc[15:8], 8'h00};
    for (int k = 0; k < 8; k++) begin
      v = v[15] ? ({v[14:0], 1'b0} ^ 16'h1021) : {v[14:0], 1'b0};
    end
    return v ^ {crc[7:0], 8'h00} ^ {8'h00, b};
  endfunction

  function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] v;
    v = {24'h0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ 32'hEDB88320) : (v >> 1);
    end
    return v ^ (crc >> 8);
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    if (c == 8'h6C) return 8'h7F;
    if (c == 8'h6D) return 8'hFF;
    return c ^ 8'h40;
  endfunction

endpackage

// File: src/zmodem_receive_deframer.sv
// zmodem receive deframer
// s_axis carries one item per transaction: a received byte (op 0) or a
// command (arm data subpacket, arm finish wait, return to idle).
// m_axis carries exactly one result per item: an event code plus the fields
// that belong to it (all other fields read zero).
// cfg carries the cancel limit (4 bits, reset 5), to be written while idle; the block itself does not enforce this.
// latency: the result of an item is presented on m_axis the cycle after the
// item is accepted. throughput: one item per cycle while m_axis_tready is high,
// set by the single output register; the crc byte update sits between the state
// and that register. s_axis_tready is high whenever the output register is empty or
// being taken in the same cycle, so a stalled receiver stops input after one item.
// reset (rst, synchronous) returns to idle mode with all counters, header
// bytes and crc cleared and the output register empty.
module zmodem_receive_deframer #(
  parameter int MAX_SUBPACKET = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // op[1:0], byte_value[9:2], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // event_res[3:0], out_byte[11:4], pad_count[19:12], header_format[21:20],
  // header_type[29:22], header_data[61:30], end_kind[63:62], crc_good[64],
  // data_length[75:65], zero fill
  output logic [79:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  // length counter wide enough for the cap, reported as its low 11 bits
  localparam int LW = (MAX_SUBPACKET > 2047) ? $clog2(MAX_SUBPACKET + 1) : 11;
  localparam logic [LW-1:0] MAXLEN = LW'(MAX_SUBPACKET);

  logic [3:0]  cancel_limit;
  logic [1:0]  input_mode, input_mode_next;
  logic [3:0]  cancel_run, cancel_run_next;
  logic [7:0]  pad_run, pad_run_next;
  logic        escape_pending, escape_pending_next;
  logic [1:0]  frame_format, frame_format_next;
  logic [4:0]  char_position, char_position_next;
  logic [7:0]  header_bytes [7];
  logic [7:0]  header_bytes_next [7];
  logic [31:0] running_crc, running_crc_next;
  logic [2:0]  crc_bytes_left, crc_bytes_left_next;
  logic [1:0]  terminator_kind, terminator_kind_next;
  logic [LW-1:0] subpacket_length, subpacket_length_next;
  logic [1:0]  finish_o_count, finish_o_count_next;

  logic [3:0]  ev;
  logic [7:0]  o_byte, o_pads, o_type;
  logic [1:0]  o_fmt, o_kind;
  logic [31:0] o_data;
  logic        o_good;
  logic [10:0] o_len;

  logic        out_valid;
  logic [79:0] out_data;
  logic        take;

  logic [1:0]  op;
  logic [7:0]  c_in;

  assign op   = s_axis_tdata[1:0];
  assign c_in = s_axis_tdata[9:2];
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign take = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_data;

  always_comb begin
    logic [7:0] c;
    logic [3:0] nib;
    logic ok, good, hdr_done, hdr_good;
    logic [2:0] idx;
    logic [3:0] lim;
    logic [15:0] c16;
    logic [31:0] c32;
    input_mode_next = input_mode;
    cancel_run_next = cancel_run;
    pad_run_next = pad_run;
    escape_pending_next = escape_pending;
    frame_format_next = frame_format;
    char_position_next = char_position;
    header_bytes_next = header_bytes;
    running_crc_next = running_crc;
    crc_bytes_left_next = crc_bytes_left;
    terminator_kind_next = terminator_kind;
    subpacket_length_next = subpacket_length;
    finish_o_count_next = finish_o_count;
    ev = zmrd_pkg::EV_NONE;
    o_byte = '0; o_pads = '0; o_type = '0; o_fmt = '0; o_kind = '0;
    o_data = '0; o_good = 1'b0; o_len = '0;
    c = c_in; nib = '0; ok = 1'b0; good = 1'b0; hdr_done = 1'b0; hdr_good = 1'b0;
    idx = '0; c16 = '0; c32 = '0;
    lim = (cancel_limit == 4'd0) ? 4'd1 : cancel_limit;

    unique case (op)
      zmrd_pkg::OP_DATA: begin
        pad_run_next = '0;
        input_mode_next = zmrd_pkg::MODE_DATA;
        subpacket_length_next = '0;
        crc_bytes_left_next = '0;
        escape_pending_next = 1'b0;
        running_crc_next = (frame_format == zmrd_pkg::FMT_BIN32) ? '1 : '0;
      end
      zmrd_pkg::OP_FINISH: begin
        input_mode_next = zmrd_pkg::MODE_FINISH;
        finish_o_count_next = '0;
        pad_run_next = '0;
        escape_pending_next = 1'b0;
      end
      zmrd_pkg::OP_IDLE: begin
        input_mode_next = zmrd_pkg::MODE_IDLE;
        char_position_next = '0;
        pad_run_next = '0;
        escape_pending_next = 1'b0;
      end
      default: begin
        if (c_in == zmrd_pkg::B_ZDLE) begin
          cancel_run_next = (cancel_run < 4'd15) ? cancel_run + 4'd1 : cancel_run;
        end else begin
          cancel_run_next = '0;
        end
        if (c_in == zmrd_pkg::B_ZDLE && cancel_run_next >= lim) begin
          ev = zmrd_pkg::EV_CANCEL;
        end else if (c_in == zmrd_pkg::B_XON || c_in == zmrd_pkg::B_XOFF) begin
          ev = zmrd_pkg::EV_NONE;
        end else begin
          unique case (input_mode)
            zmrd_pkg::MODE_IDLE: begin
              if (pad_run == 8'd0) begin
                if (c == zmrd_pkg::B_ZPAD) pad_run_next = 8'd1;
                else begin
                  ev = zmrd_pkg::EV_IDLE;
                  o_byte = c;
                end
              end else if (c == zmrd_pkg::B_ZPAD) begin
                if (pad_run != 8'hFF) pad_run_next = pad_run + 8'd1;
              end else if (c == zmrd_pkg::B_ZDLE) begin
                input_mode_next = zmrd_pkg::MODE_HEADER;
                char_position_next = '0;
                pad_run_next = '0;
                escape_pending_next = 1'b0;
              end else begin
                ev = zmrd_pkg::EV_PADS;
                o_pads = pad_run;
                pad_run_next = '0;
              end
            end
            zmrd_pkg::MODE_HEADER: begin
              if (c == zmrd_pkg::B_ZDLE) begin
                escape_pending_next = 1'b1;
              end else begin
                if (escape_pending) begin
                  escape_pending_next = 1'b0;
                  c = zmrd_pkg::unescape(c);
                end
                if (char_position == 5'd0) begin
                  if (c == 8'h42 || c == 8'h41 || c == 8'h43) begin
                    frame_format_next = (c == 8'h42) ? zmrd_pkg::FMT_HEX :
                                        (c == 8'h41) ? zmrd_pkg::FMT_BIN16 :
                                        zmrd_pkg::FMT_BIN32;
                    char_position_next = 5'd1;
                    running_crc_next = (c == 8'h43) ? '1 : '0;
                    for (int i = 0; i < 7; i++) header_bytes_next[i] = '0;
                  end else begin
                    frame_format_next = zmrd_pkg::FMT_HEX;
                    hdr_done = 1'b1;
                  end
                end else if (frame_format == zmrd_pkg::FMT_BIN16 ||
                             frame_format == zmrd_pkg::FMT_BIN32) begin
                  idx = 3'(char_position - 5'd1);
                  if (char_position <= 5'd7) header_bytes_next[idx] = c;
                  char_position_next = char_position + 5'd1;
                  if (frame_format == zmrd_pkg::FMT_BIN16) begin
                    c16 = zmrd_pkg::crc16_step(running_crc[15:0], c);
                    running_crc_next = {16'h0, c16};
                    if (char_position_next > 5'd7) begin
                      hdr_done = 1'b1;
                      hdr_good = (c16 == 16'h0) && (running_crc[31:16] == 16'h0);
                    end
                  end else begin
                    c32 = zmrd_pkg::crc32_step(running_crc, c);
                    running_crc_next = c32;
                    if (char_position_next > 5'd9) begin
                      hdr_done = 1'b1;
                      hdr_good = (c32 == zmrd_pkg::CRC32_RESIDUE);
                    end
                  end
                end else begin
                  ok = 1'b1;
                  if (c >= 8'h30 && c <= 8'h39) nib = 4'(c - 8'h30);
                  else if (c >= 8'h41 && c <= 8'h46) nib = 4'(c - 8'h37);
                  else if (c >= 8'h61 && c <= 8'h66) nib = 4'(c - 8'h57);
                  else ok = 1'b0;
                  idx = 3'((char_position - 5'd1) >> 1);
                  if (char_position <= 5'd14 && !ok) begin
                    hdr_done = 1'b1;
                  end else begin
                    if (char_position <= 5'd14) begin
                      header_bytes_next[idx] = {header_bytes[idx][3:0], nib};
                      if (!char_position[0]) begin
                        running_crc_next = {16'h0, zmrd_pkg::crc16_step(
                          running_crc[15:0], header_bytes_next[idx])};
                      end
                    end
                    if (char_position >= 5'd16) begin
                      hdr_done = 1'b1;
                      hdr_good = (running_crc[15:0] == 16'h0);
                    end else begin
                      char_position_next = char_position + 5'd1;
                    end
                  end
                end
                if (hdr_done) begin
                  input_mode_next = zmrd_pkg::MODE_IDLE;
                  char_position_next = '0;
                  o_fmt = frame_format_next;
                  if (hdr_good) begin
                    ev = zmrd_pkg::EV_HDR_GOOD;
                    o_type = header_bytes_next[0];
                    o_data = {header_bytes_next[4], header_bytes_next[3],
                              header_bytes_next[2], header_bytes_next[1]};
                  end else begin
                    ev = zmrd_pkg::EV_HDR_BAD;
                  end
                end
              end
            end
            zmrd_pkg::MODE_DATA: begin
              if (c == zmrd_pkg::B_ZDLE) begin
                escape_pending_next = 1'b1;
              end else if (escape_pending && c >= 8'h68 && c <= 8'h6B) begin
                escape_pending_next = 1'b0;
                terminator_kind_next = c[1:0];
                crc_bytes_left_next = (frame_format == zmrd_pkg::FMT_BIN32) ? 3'd4 : 3'd2;
                if (frame_format == zmrd_pkg::FMT_BIN16)
                  running_crc_next = {16'h0, zmrd_pkg::crc16_step(running_crc[15:0], c)};
                else
                  running_crc_next = zmrd_pkg::crc32_step(running_crc, c);
              end else begin
                if (escape_pending) begin
                  escape_pending_next = 1'b0;
                  c = zmrd_pkg::unescape(c);
                end
                if (frame_format == zmrd_pkg::FMT_BIN16 ||
                    frame_format == zmrd_pkg::FMT_BIN32) begin
                  c16 = zmrd_pkg::crc16_step(running_crc[15:0], c);
                  c32 = zmrd_pkg::crc32_step(running_crc, c);
                  running_crc_next = (frame_format == zmrd_pkg::FMT_BIN16) ?
                                     {16'h0, c16} : c32;
                  if (crc_bytes_left == 3'd0) begin
                    ev = zmrd_pkg::EV_DATA;
                    o_byte = c;
                    if (subpacket_length < MAXLEN)
                      subpacket_length_next = subpacket_length + LW'(1);
                  end else begin
                    crc_bytes_left_next = crc_bytes_left - 3'd1;
                    if (crc_bytes_left_next == 3'd0) begin
                      good = (frame_format == zmrd_pkg::FMT_BIN16) ? (c16 == 16'h0) :
                             (c32 == zmrd_pkg::CRC32_RESIDUE);
                      ev = zmrd_pkg::EV_SUB_END;
                      o_kind = terminator_kind;
                      o_good = good;
                      o_len = subpacket_length[10:0];
                      subpacket_length_next = '0;
                      if (terminator_kind == 2'd1 || terminator_kind == 2'd2) begin
                        crc_bytes_left_next = '0;
                        escape_pending_next = 1'b0;
                        running_crc_next = (frame_format == zmrd_pkg::FMT_BIN32) ? '1 : '0;
                      end else begin
                        input_mode_next = zmrd_pkg::MODE_IDLE;
                      end
                    end
                  end
                end
              end
            end
            default: begin
              if (c == 8'h4F) begin
                if (finish_o_count != 2'd0) begin
                  ev = zmrd_pkg::EV_FINISH;
                  finish_o_count_next = '0;
                  input_mode_next = zmrd_pkg::MODE_IDLE;
                end else begin
                  finish_o_count_next = 2'd1;
                end
              end else begin
                finish_o_count_next = '0;
              end
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cancel_limit <= 4'd5;
      input_mode <= zmrd_pkg::MODE_IDLE;
      cancel_run <= '0;
      pad_run <= '0;
      escape_pending <= 1'b0;
      frame_format <= '0;
      char_position <= '0;
      for (int i = 0; i < 7; i++) header_bytes[i] <= '0;
      running_crc <= '0;
      crc_bytes_left <= '0;
      terminator_kind <= '0;
      subpacket_length <= '0;
      finish_o_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) cancel_limit <= cfg_data;
      if (take) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
      if (take) begin
        input_mode <= input_mode_next;
        cancel_run <= cancel_run_next;
        pad_run <= pad_run_next;
        escape_pending <= escape_pending_next;
        frame_format <= frame_format_next;
        char_position <= char_position_next;
        header_bytes <= header_bytes_next;
        running_crc <= running_crc_next;
        crc_bytes_left <= crc_bytes_left_next;
        terminator_kind <= terminator_kind_next;
        subpacket_length <= subpacket_length_next;
        finish_o_count <= finish_o_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= {4'h0, o_len, o_good, o_kind, o_data, o_type, o_fmt, o_pads, o_byte, ev};
    end
  end

  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result stalled");

  // every accepted item yields a result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("missing result");

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    subpacket_length <= MAXLEN)
    else $error("subpacket length above cap");

  a_crc_left: assert property (@(posedge clk) disable iff (rst)
    crc_bytes_left <= 3'd4)
    else $error("crc byte count out of range");

endmodule
